FILE: hw/rtl/bandpass_peak_tone_detector_defines.svh
// ----------------------------------------------------------------------------
// Band-pass tone detector assertion macros
// Shared concurrent assertion forms used by the detector modules.
// ----------------------------------------------------------------------------
`ifndef BANDPASS_PEAK_TONE_DETECTOR_DEFINES_SVH
`define BANDPASS_PEAK_TONE_DETECTOR_DEFINES_SVH

// same-cycle implication, masked during reset
`define BPTD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define BPTD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/bptd_pkg.sv
// ----------------------------------------------------------------------------
// Band-pass tone detector package
// Shared types, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bptd_pkg;

   // default structure sizes
   localparam int SECTION_COUNT_DEF = 2;
   localparam int WINDOW_DEPTH_DEF  = 10;

   // field widths
   localparam int CODE_WIDTH      = 10;
   localparam int SAMPLE_WIDTH    = 24;
   localparam int MAG_WIDTH       = 24;
   localparam int GAIN_WIDTH      = 23;
   localparam int DELAY_WIDTH     = 32;
   localparam int PROD_WIDTH      = 48;
   localparam int RND_WIDTH       = 26;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_S0_FB1 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_S0_FB2 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_S1_FB1 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_S1_FB2 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEVEL  = 3'd5;

   // register reset values
   localparam logic signed [23:0] S0_FB1_RST = -24'sd6158117;
   localparam logic signed [23:0] S0_FB2_RST = 24'sd3912985;
   localparam logic signed [23:0] S1_FB1_RST = -24'sd6513690;
   localparam logic signed [23:0] S1_FB2_RST = 24'sd3934832;
   localparam logic [GAIN_WIDTH-1:0] GAIN_RST  = 23'd191316;
   localparam logic [MAG_WIDTH-1:0]  LEVEL_RST = 24'd209715;

   // multiplier operand select codes
   localparam logic [1:0] MUL_GAIN = 2'd0;
   localparam logic [1:0] MUL_A1   = 2'd1;
   localparam logic [1:0] MUL_A2   = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       sum_s;
      logic       upd_d1;
      logic       upd_d2;
      logic       finish;
   } bptd_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_sec;
      logic scan_done;
      logic out_free;
   } bptd_sts_type;

   // index width for a store of n entries
   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // code*5/1023 - 2.5 in Q4.20, nearest with ties up
   // 10485760 = 2046*5125 + 10, so the quotient splits into 5125*code
   // plus a small remainder quotient in the range 0..5
   function automatic logic signed [SAMPLE_WIDTH-1:0] centre(
      input logic [CODE_WIDTH-1:0] code);
      logic [22:0] base;
      logic [13:0] rem;
      logic [2:0]  q;
      logic [23:0] sum;
      base = 23'(code) * 23'd5125;
      rem  = 14'(code) * 14'd10 + 14'd1023;
      q    = 3'(rem >= 14'd2046) + 3'(rem >= 14'd4092) + 3'(rem >= 14'd6138)
           + 3'(rem >= 14'd8184) + 3'(rem >= 14'd10230);
      sum  = {1'b0, base} + 24'(q);
      return $signed(sum) - 24'sd2621440;
   endfunction

   // product scaled by 2^-22, nearest with ties toward +infinity
   function automatic logic signed [RND_WIDTH-1:0] rnd22(
      input logic signed [PROD_WIDTH-1:0] p);
      logic signed [PROD_WIDTH-1:0] t;
      t = p + 48'sd2097152;
      return t[PROD_WIDTH-1:22];
   endfunction

   // sign extension of a rounded product to the 33-bit work width
   function automatic logic signed [32:0] sext33(input logic signed [RND_WIDTH-1:0] v);
      return {{(33-RND_WIDTH){v[RND_WIDTH-1]}}, v};
   endfunction

   // clip to signed 24 bits
   function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
      if (v > 33'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -33'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   // clip to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bptd_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptd_ram #(
   parameter int WIDTH = bptd_pkg::MAG_WIDTH,
   parameter int DEPTH = bptd_pkg::WINDOW_DEPTH_DEF,
   localparam int AW   = bptd_pkg::idx_width(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bptd_ctrl.sv
// ----------------------------------------------------------------------------
// Band-pass tone detector controller
// Sequences the shared multiplier through each biquad section and the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bandpass_peak_tone_detector_defines.svh"

module bptd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire bptd_pkg::bptd_sts_type sts,
   output bptd_pkg::bptd_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_GAIN   = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_MA1    = 3'd3;
   localparam logic [2:0] ST_MA2    = 3'd4;
   localparam logic [2:0] ST_UPD2   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = bptd_pkg::MUL_GAIN;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bptd_pkg::MUL_GAIN;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_s = 1'b1;
            state_in  = ST_MA1;
         end
         ST_MA1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bptd_pkg::MUL_A1;
            state_in    = ST_MA2;
         end
         ST_MA2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bptd_pkg::MUL_A2;
            cmd.upd_d1  = 1'b1;
            state_in    = ST_UPD2;
         end
         ST_UPD2: begin
            cmd.upd_d2 = 1'b1;
            state_in   = sts.last_sec ? ST_FINISH : ST_GAIN;
         end
         ST_FINISH: begin
            if (sts.scan_done && sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `BPTD_ASSERT_NXT(a_load_to_gain, clock, reset, cmd.load, state_ff == ST_GAIN, "load did not start section work")
   `BPTD_ASSERT_NXT(a_more_sections, clock, reset, cmd.upd_d2 && !sts.last_sec, state_ff == ST_GAIN, "next section not started")

endmodule

`default_nettype wire

FILE: hw/rtl/bptd_dp.sv
// ----------------------------------------------------------------------------
// Band-pass tone detector datapath
// Registers, biquad arithmetic, magnitude ring scan and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bandpass_peak_tone_detector_defines.svh"

module bptd_dp #(
   parameter int SECTION_COUNT = bptd_pkg::SECTION_COUNT_DEF,
   parameter int WINDOW_DEPTH  = bptd_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_wr_en,
   input  wire logic [bptd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [bptd_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   input  wire logic [bptd_pkg::CODE_WIDTH-1:0]         req_adc_code,
   input  wire logic                                    req_report_now,
   input  wire logic                                    rsp_ready,
   output logic                                         rsp_valid,
   output logic signed [bptd_pkg::SAMPLE_WIDTH-1:0]     rsp_filtered,
   output logic        [bptd_pkg::MAG_WIDTH-1:0]        rsp_window_peak,
   output logic                                         rsp_detecting,
   output logic                                         rsp_stopped,
   output logic                                         rsp_report_valid,
   input  wire bptd_pkg::bptd_cmd_type                  cmd,
   output bptd_pkg::bptd_sts_type                       sts
);

   localparam int SW = bptd_pkg::idx_width(SECTION_COUNT);
   localparam int WW = bptd_pkg::idx_width(WINDOW_DEPTH);
   localparam int MW = bptd_pkg::MAG_WIDTH;

   // configuration registers
   logic signed [23:0]                     s0_fb1_ff, s0_fb2_ff, s1_fb1_ff, s1_fb2_ff;
   logic        [bptd_pkg::GAIN_WIDTH-1:0] gain_ff;
   logic        [MW-1:0]                   level_ff;

   // filter state
   logic signed [23:0]                     x_ff;
   logic signed [23:0]                     y_ff;
   logic signed [bptd_pkg::RND_WIDTH-1:0]  s_ff;
   logic signed [bptd_pkg::PROD_WIDTH-1:0] prod_ff;
   logic signed [bptd_pkg::PROD_WIDTH-1:0] prod_in;
   logic signed [31:0]                     d1_ff [SECTION_COUNT];
   logic signed [31:0]                     d2_ff [SECTION_COUNT];
   logic        [SW-1:0]                   sec_ff;
   logic                                   report_ff;
   logic                                   was_det_ff;

   // ring and scan state
   logic [WW-1:0]           ring_pos_ff;
   logic [WW-1:0]           ring_pos_in;
   logic [WINDOW_DEPTH-1:0] ring_valid_ff;
   logic [WW-1:0]           scan_addr_ff, scan_addr_in;
   logic                    scan_run_ff, scan_run_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [WW-1:0]           rd_idx_ff, rd_idx_in;
   logic [MW-1:0]           scan_max_ff, scan_max_in;
   logic [MW-1:0]           ram_rd_data;
   logic [MW-1:0]           entry_val;

   // result register
   logic                    rsp_valid_ff;
   logic signed [23:0]      rsp_filtered_ff;
   logic [MW-1:0]           rsp_peak_ff;
   logic                    rsp_det_ff;
   logic                    rsp_stopped_ff;
   logic                    rsp_rv_ff;

   // combinational helpers
   logic signed [23:0]                    mul_a, mul_b;
   logic signed [23:0]                    a1_sel, a2_sel;
   logic signed [bptd_pkg::RND_WIDTH-1:0] p_rnd;
   logic signed [bptd_pkg::RND_WIDTH-1:0] s_in;
   logic signed [23:0]                    y_in;
   logic        [23:0]                    y_abs;
   logic        [24:0]                    mag_wide;
   logic        [MW-1:0]                  mag;
   logic        [MW-1:0]                  peak;
   logic                                  det;
   logic                                  last_sec;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_fb1_ff <= bptd_pkg::S0_FB1_RST;
         s0_fb2_ff <= bptd_pkg::S0_FB2_RST;
         s1_fb1_ff <= bptd_pkg::S1_FB1_RST;
         s1_fb2_ff <= bptd_pkg::S1_FB2_RST;
         gain_ff   <= bptd_pkg::GAIN_RST;
         level_ff  <= bptd_pkg::LEVEL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            bptd_pkg::CSR_S0_FB1: s0_fb1_ff <= $signed(csr_data[23:0]);
            bptd_pkg::CSR_S0_FB2: s0_fb2_ff <= $signed(csr_data[23:0]);
            bptd_pkg::CSR_S1_FB1: s1_fb1_ff <= $signed(csr_data[23:0]);
            bptd_pkg::CSR_S1_FB2: s1_fb2_ff <= $signed(csr_data[23:0]);
            bptd_pkg::CSR_GAIN:   gain_ff   <= csr_data[bptd_pkg::GAIN_WIDTH-1:0];
            bptd_pkg::CSR_LEVEL:  level_ff  <= csr_data[MW-1:0];
            default: begin
            end
         endcase
      end
   end

   // coefficient select: sections past the first share the second set
   assign a1_sel   = (sec_ff == '0) ? s0_fb1_ff : s1_fb1_ff;
   assign a2_sel   = (sec_ff == '0) ? s0_fb2_ff : s1_fb2_ff;
   assign last_sec = (sec_ff == SW'(SECTION_COUNT - 1));

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         bptd_pkg::MUL_GAIN: begin
            mul_a = x_ff;
            mul_b = $signed({1'b0, gain_ff});
         end
         bptd_pkg::MUL_A1: begin
            mul_a = y_ff;
            mul_b = a1_sel;
         end
         bptd_pkg::MUL_A2: begin
            mul_a = y_ff;
            mul_b = a2_sel;
         end
         default: begin
            mul_a = y_ff;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign p_rnd   = bptd_pkg::rnd22(prod_ff);
   assign s_in    = p_rnd;
   assign y_in    = bptd_pkg::sat24(bptd_pkg::sext33(s_in) + {d1_ff[sec_ff][31], d1_ff[sec_ff]});

   // section arithmetic and delay registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SECTION_COUNT; i++) begin
            d1_ff[i] <= '0;
            d2_ff[i] <= '0;
         end
         sec_ff <= '0;
      end else begin
         if (cmd.load) begin
            sec_ff <= '0;
         end else if (cmd.upd_d2 && !last_sec) begin
            sec_ff <= sec_ff + SW'(1);
         end
         if (cmd.upd_d1) begin
            d1_ff[sec_ff] <= bptd_pkg::sat32({d2_ff[sec_ff][31], d2_ff[sec_ff]}
                                             - bptd_pkg::sext33(p_rnd));
         end
         if (cmd.upd_d2) begin
            d2_ff[sec_ff] <= bptd_pkg::sat32(-bptd_pkg::sext33(s_ff)
                                             - bptd_pkg::sext33(p_rnd));
         end
      end
   end

   // sample, product and section payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff      <= bptd_pkg::centre(req_adc_code);
         report_ff <= req_report_now;
      end else if (cmd.upd_d2) begin
         x_ff <= y_ff;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.sum_s) begin
         s_ff <= s_in;
         y_ff <= y_in;
      end
   end

   // window scan, the slot about to be overwritten counts as empty
   assign entry_val = (ring_valid_ff[rd_idx_ff] && (rd_idx_ff != ring_pos_ff))
                      ? ram_rd_data : '0;

   always_comb begin
      scan_addr_in = scan_addr_ff;
      scan_run_in  = scan_run_ff;
      scan_max_in  = scan_max_ff;
      rd_pend_in   = scan_run_ff;
      rd_idx_in    = scan_addr_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
         scan_run_in  = 1'b1;
         scan_max_in  = '0;
         rd_pend_in   = 1'b0;
      end else begin
         if (scan_run_ff) begin
            if (scan_addr_ff == WW'(WINDOW_DEPTH - 1)) begin
               scan_run_in = 1'b0;
            end else begin
               scan_addr_in = scan_addr_ff + WW'(1);
            end
         end
         if (rd_pend_ff && (entry_val > scan_max_ff)) begin
            scan_max_in = entry_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
      end else begin
         scan_run_ff <= scan_run_in;
         rd_pend_ff  <= rd_pend_in;
      end
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      scan_max_ff  <= scan_max_in;
   end

   // magnitude ring
   bptd_ram #(
      .WIDTH (MW),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.finish),
      .wr_addr (ring_pos_ff),
      .wr_data (mag),
      .rd_en   (scan_run_ff),
      .rd_addr (scan_addr_ff),
      .rd_data (ram_rd_data)
   );

   // magnitude 2|y| clipped, window peak and threshold
   assign y_abs    = y_ff[23] ? 24'(-y_ff) : y_ff;
   assign mag_wide = {y_abs, 1'b0};
   assign mag      = mag_wide[24] ? {MW{1'b1}} : mag_wide[MW-1:0];
   assign peak     = (mag > scan_max_ff) ? mag : scan_max_ff;
   assign det      = (peak > level_ff);

   assign ring_pos_in = (ring_pos_ff == WW'(WINDOW_DEPTH - 1)) ? '0 : ring_pos_ff + WW'(1);

   // ring position, valid bits, detection history and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_pos_ff   <= '0;
         ring_valid_ff <= '0;
         was_det_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.finish) begin
            ring_pos_ff                <= ring_pos_in;
            ring_valid_ff[ring_pos_ff] <= 1'b1;
            if (report_ff) begin
               was_det_ff <= det;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_filtered_ff <= y_ff;
         rsp_peak_ff     <= report_ff ? peak : '0;
         rsp_det_ff      <= report_ff && det;
         rsp_stopped_ff  <= report_ff && !det && was_det_ff;
         rsp_rv_ff       <= report_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered     = rsp_filtered_ff;
   assign rsp_window_peak  = rsp_peak_ff;
   assign rsp_detecting    = rsp_det_ff;
   assign rsp_stopped      = rsp_stopped_ff;
   assign rsp_report_valid = rsp_rv_ff;

   assign sts.last_sec  = last_sec;
   assign sts.scan_done = !scan_run_ff && !rd_pend_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // checks
   `BPTD_ASSERT_IMP(a_scan_quiet, clock, reset, cmd.finish, !scan_run_ff && !rd_pend_ff, "result taken before window scan ended")
   `BPTD_ASSERT_IMP(a_stop_fields, clock, reset, rsp_valid_ff && rsp_stopped_ff, rsp_rv_ff && !rsp_det_ff, "stop event without a report drop")
   `BPTD_ASSERT_NXT(a_slot_valid, clock, reset, cmd.finish, ring_valid_ff[$past(ring_pos_ff)], "written ring slot not marked")

endmodule

`default_nettype wire

FILE: hw/rtl/bandpass_peak_tone_detector.sv
// ----------------------------------------------------------------------------
// Band-pass peak tone detector
// Two-section scaled biquad band-pass with a peak window and threshold report.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                  payload
//   req_      in          req_valid / req_ready      adc_code, report_now
//   rsp_      out         rsp_valid / rsp_ready      filtered, window_peak,
//                                                    detecting, stopped, report_valid
//   csr_      in          csr_wr_en                  csr_index, csr_data
//
// One beat at a time: a result is registered once the section work and the
// window scan (one ring entry a cycle) are both through; the filter uses one
// shared 24x24 multiplier for five steps per section. A new input beat is taken
// the cycle after the result is registered, even while rsp_ready is low; the
// next result then waits for the output register. Synchronous reset empties all.
`timescale 1ns / 1ps
`default_nettype none

module bandpass_peak_tone_detector #(
   parameter int SECTION_COUNT = bptd_pkg::SECTION_COUNT_DEF,
   parameter int WINDOW_DEPTH  = bptd_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [bptd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [bptd_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [bptd_pkg::CODE_WIDTH-1:0]       req_adc_code,
   input  wire logic                                  req_report_now,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [bptd_pkg::SAMPLE_WIDTH-1:0]   rsp_filtered,
   output logic        [bptd_pkg::MAG_WIDTH-1:0]      rsp_window_peak,
   output logic                                       rsp_detecting,
   output logic                                       rsp_stopped,
   output logic                                       rsp_report_valid
);

   bptd_pkg::bptd_cmd_type cmd;
   bptd_pkg::bptd_sts_type sts;

   // sequencer
   bptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, ring and result register
   bptd_dp #(
      .SECTION_COUNT (SECTION_COUNT),
      .WINDOW_DEPTH  (WINDOW_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_adc_code     (req_adc_code),
      .req_report_now   (req_report_now),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_filtered     (rsp_filtered),
      .rsp_window_peak  (rsp_window_peak),
      .rsp_detecting    (rsp_detecting),
      .rsp_stopped      (rsp_stopped),
      .rsp_report_valid (rsp_report_valid),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

`default_nettype wire

FILE: tb/sv/bandpass_peak_tone_detector_tb.sv
// ----------------------------------------------------------------------------
// Band-pass peak tone detector testbench
// Sends converter samples with report flags, predicts every result beat with
// a bit-accurate model of the biquad cascade and peak window, and compares
// each result field in order. Runs several register settings and idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bandpass_peak_tone_detector_tb;
   import bptd_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 4;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SECTIONS     = SECTION_COUNT_DEF;
   localparam int WINDOW       = WINDOW_DEPTH_DEF;

   // register indexes outside the map, writes must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   // numeric limits of the datapath
   localparam longint Y_MAX     = 64'sd8388607;
   localparam longint Y_MIN     = -64'sd8388608;
   localparam longint DELAY_MAX = 64'sd2147483647;
   localparam longint DELAY_MIN = -64'sd2147483648;
   localparam longint MAG_LIMIT = 64'sd16777215;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] filtered;
      logic [MAG_WIDTH-1:0]           window_peak;
      logic                           detecting;
      logic                           stopped;
      logic                           report_valid;
   } tone_result_type;

   // predicts result beats from accepted samples and checks them in order
   class tone_scoreboard;
      logic signed [23:0]      fb1_first, fb2_first, fb1_rest, fb2_rest;
      logic [GAIN_WIDTH-1:0]   gain;
      logic [MAG_WIDTH-1:0]    level;
      longint                  dly1[SECTIONS];
      longint                  dly2[SECTIONS];
      logic [MAG_WIDTH-1:0]    mag_ring[WINDOW];
      int                      ring_pos;
      bit                      was_det;
      tone_result_type         expected_reports[$];
      int                      fail_count;

      function new();
         fb1_first  = S0_FB1_RST;
         fb2_first  = S0_FB2_RST;
         fb1_rest   = S1_FB1_RST;
         fb2_rest   = S1_FB2_RST;
         gain       = GAIN_RST;
         level      = LEVEL_RST;
         foreach (dly1[k]) dly1[k] = 0;
         foreach (dly2[k]) dly2[k] = 0;
         foreach (mag_ring[k]) mag_ring[k] = '0;
         ring_pos   = 0;
         was_det    = 1'b0;
         fail_count = 0;
      endfunction

      // product scaled down by 2^22, nearest with ties upward
      function longint scale_round(longint v);
         return (v + 64'sd2097152) >>> 22;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_S0_FB1: fb1_first = data;
            CSR_S0_FB2: fb2_first = data;
            CSR_S1_FB1: fb1_rest  = data;
            CSR_S1_FB2: fb2_rest  = data;
            CSR_GAIN:   gain      = data[GAIN_WIDTH-1:0];
            CSR_LEVEL:  level     = data;
            default: ;
         endcase
      endfunction

      function void note_sample(logic [CODE_WIDTH-1:0] code, logic report);
         longint       x, y, s, a1, a2, d1_next, mag;
         logic [MAG_WIDTH-1:0] peak;
         logic         det;
         int           k;
         tone_result_type want;
         // centre the code to volts, nearest with ties up
         x = ((longint'(code) * 10485760 + 1023) / 2046) - 2621440;
         y = 0;
         // transposed direct form II sections, numerator 1, 0, -1
         for (k = 0; k < SECTIONS; k++) begin
            a1 = (k == 0) ? longint'(fb1_first) : longint'(fb1_rest);
            a2 = (k == 0) ? longint'(fb2_first) : longint'(fb2_rest);
            s  = scale_round(x * longint'(gain));
            y  = clip(s + dly1[k], Y_MIN, Y_MAX);
            d1_next = clip(dly2[k] - scale_round(a1 * y), DELAY_MIN, DELAY_MAX);
            dly2[k] = clip(-s - scale_round(a2 * y), DELAY_MIN, DELAY_MAX);
            dly1[k] = d1_next;
            x = y;
         end
         // push doubled magnitude into the window
         mag = (y < 0) ? -y : y;
         mag = clip(mag * 2, 0, MAG_LIMIT);
         mag_ring[ring_pos] = mag[MAG_WIDTH-1:0];
         ring_pos = (ring_pos + 1) % WINDOW;
         want = '0;
         want.filtered = y[SAMPLE_WIDTH-1:0];
         // window evaluation only on report samples
         if (report) begin
            peak = '0;
            for (k = 0; k < WINDOW; k++) begin
               if (mag_ring[k] > peak) peak = mag_ring[k];
            end
            det = peak > level;
            want.window_peak  = peak;
            want.detecting    = det;
            want.stopped      = !det && was_det;
            want.report_valid = 1'b1;
            was_det = det;
         end
         expected_reports.push_back(want);
      endfunction

      function void check_report(tone_result_type got);
         tone_result_type want;
         if (expected_reports.size() == 0) begin
            $error("result beat with no sample outstanding, filtered %0d",
                   $signed(got.filtered));
            fail_count++;
            return;
         end
         want = expected_reports.pop_front();
         if (got.filtered !== want.filtered) begin
            $error("filtered expected %0d actual %0d",
                   $signed(want.filtered), $signed(got.filtered));
            fail_count++;
         end
         if (got.window_peak !== want.window_peak) begin
            $error("window_peak expected %0d actual %0d", want.window_peak, got.window_peak);
            fail_count++;
         end
         if (got.detecting !== want.detecting) begin
            $error("detecting expected %0b actual %0b", want.detecting, got.detecting);
            fail_count++;
         end
         if (got.stopped !== want.stopped) begin
            $error("stopped expected %0b actual %0b", want.stopped, got.stopped);
            fail_count++;
         end
         if (got.report_valid !== want.report_valid) begin
            $error("report_valid expected %0b actual %0b",
                   want.report_valid, got.report_valid);
            fail_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CODE_WIDTH-1:0] req_adc_code = '0;
   logic req_report_now = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered;
   logic [MAG_WIDTH-1:0] rsp_window_peak;
   logic rsp_detecting;
   logic rsp_stopped;
   logic rsp_report_valid;

   int send_idle_pct = 0;
   int ready_stall_pct = 0;
   int hold_off_cycles = 0;
   int cycle_count = 0;

   tone_scoreboard sb;

   bandpass_peak_tone_detector dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_code     (req_adc_code),
      .req_report_now   (req_report_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filtered     (rsp_filtered),
      .rsp_window_peak  (rsp_window_peak),
      .rsp_detecting    (rsp_detecting),
      .rsp_stopped      (rsp_stopped),
      .rsp_report_valid (rsp_report_valid)
   );

   // clock
   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: check accepted beats, then pick next ready
   initial begin : rsp_side
      tone_result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.filtered     = rsp_filtered;
            got.window_peak  = rsp_window_peak;
            got.detecting    = rsp_detecting;
            got.stopped      = rsp_stopped;
            got.report_valid = rsp_report_valid;
            sb.check_report(got);
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= ready_stall_pct);
         end
      end
   end

   // offer one sample beat and wait for it to be taken
   task automatic send_sample(input logic [CODE_WIDTH-1:0] code, input logic report);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_code   <= code;
      req_report_now <= report;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(code, report);
   endtask

   // let every result drain and the block go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // full register load, spare indexes get junk that must be dropped
   task automatic load_settings(input logic [23:0] fb1a, input logic [23:0] fb2a,
                                input logic [23:0] fb1b, input logic [23:0] fb2b,
                                input logic [GAIN_WIDTH-1:0] g, input logic [23:0] lvl);
      csr_write(CSR_SPARE_LO, 24'($urandom()));
      csr_write(CSR_S0_FB1, fb1a);
      csr_write(CSR_S0_FB2, fb2a);
      csr_write(CSR_S1_FB1, fb1b);
      csr_write(CSR_S1_FB2, fb2b);
      csr_write(CSR_GAIN, {1'($urandom_range(1)), g});
      csr_write(CSR_SPARE_HI, 24'($urandom()));
      csr_write(CSR_LEVEL, lvl);
      csr_wr_en <= 1'b0;
   endtask

   // tone bursts with ringdown gaps, mixed with raw noise
   task automatic play_bursts(input int count);
      int sent, kind, len, period, amp, quiet, i;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(9);
         if (kind < 7) begin
            len    = $urandom_range(40, 4);
            period = $urandom_range(12, 6);
            amp    = $urandom_range(511);
            for (i = 0; i < len && sent < count; i++) begin
               send_sample(((i % period) < period / 2) ? 10'(512 + amp) : 10'(512 - amp),
                           $urandom_range(3) == 0);
               sent++;
            end
            quiet = $urandom_range(80);
            for (i = 0; i < quiet && sent < count; i++) begin
               send_sample(10'(511 + $urandom_range(1)), $urandom_range(3) == 0);
               sent++;
            end
         end else begin
            len = $urandom_range(20, 1);
            for (i = 0; i < len && sent < count; i++) begin
               send_sample(10'($urandom_range(1023)), $urandom_range(1) == 1);
               sent++;
            end
         end
      end
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input int hold,
                            input int count);
      send_idle_pct   = send_pct;
      ready_stall_pct = stall_pct;
      hold_off_cycles = hold;
      play_bursts(count);
      settle();
   endtask

   // main sequence
   initial begin
      int i;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: cleared window, code extremes, report and quiet samples
      send_sample(10'd512, 1'b1);
      for (i = 0; i < 16; i++) begin
         send_sample((i % 2 == 1) ? 10'd1023 : 10'd0, i % 4 == 3);
      end
      send_sample(10'd511, 1'b0);
      send_sample(10'd1, 1'b1);
      send_sample(10'd1022, 1'b0);
      for (i = 0; i < 4; i++) begin
         send_sample(10'd512, 1'b1);
      end
      settle();

      // reset settings under each idle mix, long receiver hold once
      run_phase(74, 0, 0, 110);
      run_phase(0, 74, 300, 110);

      // reset coefficients written back, random threshold
      load_settings(S0_FB1_RST, S0_FB2_RST, S1_FB1_RST, S1_FB2_RST, GAIN_RST,
                    24'($urandom_range(800000, 100000)));
      run_phase(16, 16, 0, 110);

      // extremes: unstable feedback, full gain, zero threshold
      load_settings(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 23'h7FFFFF, 24'h000000);
      run_phase(0, 0, 0, 80);

      // opposite extremes: zero gain, top threshold
      load_settings(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 23'h000000, 24'hFFFFFF);
      run_phase(16, 16, 0, 60);

      // fully random settings
      load_settings(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                    23'($urandom()), 24'($urandom()));
      run_phase(74, 0, 0, 110);
      load_settings(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                    23'($urandom()), 24'($urandom()));
      run_phase(0, 74, 0, 110);

      // stable filters near the reset tuning
      load_settings(S0_FB1_RST + 24'($urandom_range(65535)) - 24'd32768,
                    S0_FB2_RST + 24'($urandom_range(32767)) - 24'd16384,
                    S1_FB1_RST + 24'($urandom_range(65535)) - 24'd32768,
                    S1_FB2_RST + 24'($urandom_range(32767)) - 24'd16384,
                    23'($urandom_range(400000)), 24'($urandom_range(2000000)));
      run_phase(16, 16, 0, 110);

      // reset tuning, threshold at zero
      load_settings(S0_FB1_RST, S0_FB2_RST, S1_FB1_RST, S1_FB2_RST, GAIN_RST, 24'h000000);
      run_phase(0, 0, 0, 125);

      if (sb.fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/bptd_pkg.sv
hw/rtl/bptd_ram.sv
hw/rtl/bptd_ctrl.sv
hw/rtl/bptd_dp.sv
hw/rtl/bandpass_peak_tone_detector.sv
tb/sv/bandpass_peak_tone_detector_tb.sv
